// ===== design/text_console_cell_writer_macros.svh =====
// assertion macros for the text console cell writer checker
// no dependencies; included by the checker file
`ifndef TEXT_CONSOLE_CELL_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CELL_WRITER_MACROS_SVH

// same-cycle implication, disabled during reset
`define TCCW_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define TCCW_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tccw_pkg.sv =====
// shared constants and helpers for the text console cell writer
// no dependencies; used by the interfaces, the top level and the checker
package tccw_pkg;

  localparam int MODE_W      = 2;
  localparam int CHAR_W      = 8;
  localparam int NUM_W       = 32;
  localparam int ADDR_W      = 11;
  localparam int WORD_W      = 16;
  localparam int COLOR_W     = 8;
  localparam int NIB_W       = 4;
  localparam int DIGITS      = 10;
  localparam int BCD_W       = DIGITS * NIB_W;
  localparam int DCNT_W      = $clog2(DIGITS + 1);
  localparam int BCNT_W      = $clog2(NUM_W);
  // holds row*COLUMNS+column for the largest screen (255 x 255)
  localparam int WIDE_ADDR_W = 16;

  localparam logic [MODE_W-1:0]  MODE_CHAR   = 2'd0;
  localparam logic [MODE_W-1:0]  MODE_DEC    = 2'd1;
  localparam logic [MODE_W-1:0]  MODE_HEX    = 2'd2;
  localparam logic [CHAR_W-1:0]  NEWLINE     = 8'd10;
  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'd7;
  localparam logic [CHAR_W-1:0]  GLYPH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0]  GLYPH_A     = 8'h41;
  localparam logic [NIB_W-1:0]   TEN         = 4'd10;

  // upper-case hex glyph of one nibble
  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [NIB_W-1:0] d);
    logic [CHAR_W-1:0] g;
    if (d < TEN) begin
      g = GLYPH_ZERO + CHAR_W'(d);
    end else begin
      g = GLYPH_A + CHAR_W'(d - TEN);
    end
    return g;
  endfunction

endpackage

// ===== design/tccw_if.sv =====
// valid/ready channel interfaces: command, cell write and color register
// depends on tccw_pkg
interface tccw_cmd_if;
  import tccw_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [CHAR_W-1:0]   char_code;
  logic [NUM_W-1:0]    number;
  modport source (output valid, mode, char_code, number, input ready);
  modport sink   (input valid, mode, char_code, number, output ready);
endinterface

interface tccw_cell_if;
  import tccw_pkg::*;
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   cell_address;
  logic [WORD_W-1:0]   cell_word;
  logic                last;
  modport source (output valid, cell_address, cell_word, last, input ready);
  modport sink   (input valid, cell_address, cell_word, last, output ready);
endinterface

interface tccw_cfg_if;
  import tccw_pkg::*;
  logic                valid;
  logic                ready;
  logic [COLOR_W-1:0]  text_color;
  modport source (output valid, text_color, input ready);
  modport sink   (input valid, text_color, output ready);
endinterface

// ===== design/text_console_cell_writer.sv =====
// channel | direction | carries
// cmd     | in        | mode, char_code, number
// cells   | out       | cell_address, cell_word, last
// cfg     | in        | text_color register write
//
// a character is accepted and then its cell is written; a number is accepted,
// then its leading zero digits are skipped, keeping at least one digit (hex has
// two to nine of them, decimal up to nine), then its digits are written msd first;
// decimal first runs bit-serial binary to bcd conversion before the skip
// (one bit per cycle)
// the cell output register sets the pace of digit writes: one per cycle
// while cells.ready is high, holding while it is low
// rst (synchronous) puts the cursor at 0,0 and the color at 7
// depends on tccw_pkg and the channel interfaces in tccw_if.sv
module text_console_cell_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic           clk,
  input  logic           rst,
  tccw_cmd_if.sink       cmd,
  tccw_cell_if.source    cells,
  tccw_cfg_if.sink       cfg
);
  import tccw_pkg::*;

  localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  // sequencer codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;  // double dabble, one bit a cycle
  localparam logic [1:0] S_SKIP = 2'd2;  // drop leading zero digits
  localparam logic [1:0] S_EMIT = 2'd3;  // one digit written a cycle while the output register is free

  logic [1:0]             state;
  logic [COLOR_W-1:0]     color;
  logic [COL_W-1:0]       col;
  logic [ROW_W-1:0]       row;
  logic [WIDE_ADDR_W-1:0] addr;

  // digit datapath: bcd holds digits msd first, bin feeds conversion bits
  logic [BCD_W-1:0]       bcd;
  logic [BCD_W-1:0]       bcd_adj;
  logic [NUM_W-1:0]       bin;
  logic [BCNT_W-1:0]      bit_cnt;
  logic [DCNT_W-1:0]      dig_cnt;
  logic                   is_char;
  logic [CHAR_W-1:0]      char_reg;

  // cell output register
  logic                   cell_valid;
  logic [ADDR_W-1:0]      out_addr;
  logic [WORD_W-1:0]      out_word;
  logic                   out_last;

  // cursor moves
  logic [COL_W-1:0]       adv_col;
  logic [ROW_W-1:0]       adv_row;
  logic [WIDE_ADDR_W-1:0] adv_addr;
  logic [ROW_W-1:0]       nl_row;
  logic [WIDE_ADDR_W-1:0] nl_addr;
  logic                   at_bottom;
  logic                   at_line_end;
  logic [NIB_W-1:0]       top_digit;
  logic [CHAR_W-1:0]      glyph;
  logic                   emit_go;

  assign cmd.ready          = (state == S_IDLE);
  assign cfg.ready          = 1'b1;
  assign cells.valid        = cell_valid;
  assign cells.cell_address = out_addr;
  assign cells.cell_word    = out_word;
  assign cells.last         = out_last;

  assign at_bottom   = (row == ROW_W'(ROWS - 1));
  assign at_line_end = (col == COL_W'(COLUMNS - 1));
  assign top_digit   = bcd[BCD_W-1 -: NIB_W];
  assign glyph       = is_char ? char_reg : digit_glyph(top_digit);
  // output register free, or being emptied this cycle
  assign emit_go     = !cell_valid || cells.ready;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[i*NIB_W +: NIB_W] >= 4'd5) begin
        bcd_adj[i*NIB_W +: NIB_W] = bcd[i*NIB_W +: NIB_W] + 4'd3;
      end else begin
        bcd_adj[i*NIB_W +: NIB_W] = bcd[i*NIB_W +: NIB_W];
      end
    end
  end

  // cursor after one written cell, and after a newline
  always_comb begin
    if (at_line_end) begin
      adv_col = '0;
      adv_row = at_bottom ? '0 : row + 1'b1;
    end else begin
      adv_col = col + 1'b1;
      adv_row = row;
    end
    // addr+1 also covers the line wrap; only the screen wrap returns to 0
    adv_addr = (at_line_end && at_bottom) ? '0 : addr + 1'b1;
    nl_row   = at_bottom ? '0 : row + 1'b1;
    nl_addr  = at_bottom ? '0
             : addr - WIDE_ADDR_W'(col) + WIDE_ADDR_W'(COLUMNS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      color      <= RESET_COLOR;
      col        <= '0;
      row        <= '0;
      addr       <= '0;
      cell_valid <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        color <= cfg.text_color;
      end
      // in the emit state the register is refilled instead
      if (cell_valid && cells.ready && state != S_EMIT) begin
        cell_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            priority if (cmd.mode == MODE_CHAR) begin
              if (cmd.char_code == NEWLINE) begin
                // newline: no cell, cursor to start of next row
                col  <= '0;
                row  <= nl_row;
                addr <= nl_addr;
              end else begin
                is_char  <= 1'b1;
                char_reg <= cmd.char_code;
                dig_cnt  <= DCNT_W'(1);
                state    <= S_EMIT;
              end
            end else if (cmd.mode == MODE_DEC) begin
              is_char <= 1'b0;
              bin     <= cmd.number;
              bcd     <= '0;
              bit_cnt <= '0;
              state   <= S_CONV;
            end else if (cmd.mode == MODE_HEX) begin
              // hex digits are the number's nibbles, top ones zero
              is_char <= 1'b0;
              bcd     <= BCD_W'(cmd.number);
              dig_cnt <= DCNT_W'(DIGITS);
              state   <= S_SKIP;
            end else begin
              // unused mode: taken and dropped
              state <= S_IDLE;
            end
          end
        end
        S_CONV: begin
          {bcd, bin} <= {bcd_adj[BCD_W-2:0], bin, 1'b0};
          bit_cnt    <= bit_cnt + 1'b1;
          if (bit_cnt == BCNT_W'(NUM_W - 1)) begin
            dig_cnt <= DCNT_W'(DIGITS);
            state   <= S_SKIP;
          end
        end
        S_SKIP: begin
          // keep at least one digit so zero prints as 0
          if (top_digit == '0 && dig_cnt > DCNT_W'(1)) begin
            bcd     <= {bcd[BCD_W-NIB_W-1:0], {NIB_W{1'b0}}};
            dig_cnt <= dig_cnt - 1'b1;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            cell_valid <= 1'b1;
            out_addr   <= addr[ADDR_W-1:0];
            out_word   <= {color, glyph};
            out_last   <= (dig_cnt == DCNT_W'(1));
            col        <= adv_col;
            row        <= adv_row;
            addr       <= adv_addr;
            bcd        <= {bcd[BCD_W-NIB_W-1:0], {NIB_W{1'b0}}};
            dig_cnt    <= dig_cnt - 1'b1;
            if (dig_cnt == DCNT_W'(1)) begin
              state <= S_IDLE;
            end
          end else if (cell_valid && cells.ready) begin
            cell_valid <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/tccw_checker.sv =====
// port-level checks for the text console cell writer, bound to the top level
// depends on tccw_pkg and text_console_cell_writer_macros.svh
`include "text_console_cell_writer_macros.svh"

module tccw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        cmd_valid,
  input logic                        cmd_ready,
  input logic [tccw_pkg::MODE_W-1:0] cmd_mode,
  input logic [tccw_pkg::CHAR_W-1:0] cmd_char_code,
  input logic                        cell_valid,
  input logic                        cell_ready,
  input logic [tccw_pkg::ADDR_W-1:0] cell_address,
  input logic [tccw_pkg::WORD_W-1:0] cell_word,
  input logic                        cell_last
);
  import tccw_pkg::*;

  localparam int  CELLS     = COLUMNS * ROWS;
  localparam bit  ADDR_FITS = (CELLS <= (1 << ADDR_W));

  logic cmd_take;
  logic no_cell_cmd;

  assign cmd_take    = cmd_valid && cmd_ready;
  assign no_cell_cmd = (cmd_mode == MODE_CHAR && cmd_char_code == NEWLINE)
                    || (cmd_mode != MODE_CHAR && cmd_mode != MODE_DEC
                        && cmd_mode != MODE_HEX);

  // a stalled cell write keeps its payload
  `TCCW_ASSERT_NXT(a_cell_hold, clk, rst, cell_valid && !cell_ready,
    cell_valid && $stable(cell_address) && $stable(cell_word) && $stable(cell_last),
    "stalled cell write changed")

  // no new command while an item still has cell writes to come
  `TCCW_ASSERT_IMP(a_no_cmd_mid_item, clk, rst, cell_valid && !cell_last,
    !cmd_ready, "command accepted in the middle of an item")

  // newline and unused mode write no cell
  `TCCW_ASSERT_NXT(a_silent_cmd, clk, rst, cmd_take && no_cell_cmd,
    !$rose(cell_valid), "cell write from a command that writes none")

  // address stays on the screen when it fits the address field
  `TCCW_ASSERT_IMP(a_addr_range, clk, rst, cell_valid && ADDR_FITS,
    32'(cell_address) < 32'(CELLS), "cell address off the screen")

endmodule

bind text_console_cell_writer tccw_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tccw_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .cmd_mode     (cmd.mode),
  .cmd_char_code(cmd.char_code),
  .cell_valid   (cells.valid),
  .cell_ready   (cells.ready),
  .cell_address (cells.cell_address),
  .cell_word    (cells.cell_word),
  .cell_last    (cells.last)
);

// ===== bench/text_console_cell_writer_checker.sv =====
// checker for the text console cell writer: predicts every cell write and compares
// depends on tccw_pkg and the channel interfaces in tccw_if.sv
module text_console_cell_writer_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic  clk,
  input  logic  rst,
  tccw_cmd_if   cmd,
  tccw_cell_if  cells,
  tccw_cfg_if   cfg,
  output int    errors,
  output int    outstanding,
  output int    cells_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import tccw_pkg::*;

  localparam int SHOWN_MISMATCHES = 10;
  localparam int DEC_BASE         = 10;

  typedef struct packed {
    logic [ADDR_W-1:0] cell_address;
    logic [WORD_W-1:0] cell_word;
    logic              last;
  } cell_write_t;

  cell_write_t        expected_cells[$];
  logic [COLOR_W-1:0] color = RESET_COLOR;
  int unsigned        cursor_col = 0;
  int unsigned        cursor_row = 0;
  int                 mismatch_count = 0;
  int                 checked_count = 0;

  function automatic logic [CHAR_W-1:0] glyph_of(input logic [NIB_W-1:0] d);
    if (d < NIB_W'(DEC_BASE)) begin
      return CHAR_W'("0") + CHAR_W'(d);
    end
    return CHAR_W'("A") + CHAR_W'(d - NIB_W'(DEC_BASE));
  endfunction

  task automatic step_row();
    if (cursor_row + 1 >= ROWS) begin
      cursor_row = 0;
    end else begin
      cursor_row = cursor_row + 1;
    end
  endtask

  // one cell write at the cursor, then advance with line and screen wrap
  task automatic queue_cell(input logic [CHAR_W-1:0] ch, input logic is_last);
    cell_write_t w;
    w.cell_address = ADDR_W'(cursor_row * COLUMNS + cursor_col);
    w.cell_word    = {color, ch};
    w.last         = is_last;
    expected_cells.push_back(w);
    cursor_col = cursor_col + 1;
    if (cursor_col >= COLUMNS) begin
      cursor_col = 0;
      step_row();
    end
  endtask

  task automatic predict_cell_writes(input logic [MODE_W-1:0] mode,
                                     input logic [CHAR_W-1:0] ch,
                                     input logic [NUM_W-1:0]  num);
    logic [CHAR_W-1:0] glyphs [DIGITS];
    logic [NUM_W-1:0]  rest;
    int                n;
    n    = 0;
    rest = num;
    case (mode)
      MODE_CHAR: begin
        if (ch == NEWLINE) begin
          cursor_col = 0;
          step_row();
        end else begin
          queue_cell(ch, 1'b1);
        end
      end
      MODE_DEC: begin
        do begin
          glyphs[n] = glyph_of(NIB_W'(rest % DEC_BASE));
          rest      = rest / DEC_BASE;
          n++;
        end while (rest != 0);
      end
      MODE_HEX: begin
        do begin
          glyphs[n] = glyph_of(rest[NIB_W-1:0]);
          rest      = rest >> NIB_W;
          n++;
        end while (rest != 0);
      end
      default: begin
        // unused mode: no write, cursor stays
      end
    endcase
    // most significant digit first
    for (int k = n - 1; k >= 0; k--) begin
      queue_cell(glyphs[k], k == 0);
    end
  endtask

  always @(posedge clk) begin
    cell_write_t got;
    cell_write_t want;
    if (rst) begin
      expected_cells.delete();
      color      = RESET_COLOR;
      cursor_col = 0;
      cursor_row = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        color = cfg.text_color;
      end
      if (cells.valid && cells.ready) begin
        got = {cells.cell_address, cells.cell_word, cells.last};
        checked_count++;
        if (expected_cells.size() == 0) begin
          if (mismatch_count < SHOWN_MISMATCHES) begin
            $display("unexpected cell write: addr %0d word %h last %b",
                     got.cell_address, got.cell_word, got.last);
          end
          mismatch_count++;
        end else begin
          want = expected_cells.pop_front();
          if (got.cell_address !== want.cell_address || got.cell_word !== want.cell_word ||
              got.last !== want.last) begin
            if (mismatch_count < SHOWN_MISMATCHES) begin
              $display("cell write %0d: expected addr %0d word %h last %b, got addr %0d word %h last %b",
                       checked_count, want.cell_address, want.cell_word, want.last,
                       got.cell_address, got.cell_word, got.last);
            end
            mismatch_count++;
          end
        end
      end
      if (cmd.valid && cmd.ready) begin
        predict_cell_writes(cmd.mode, cmd.char_code, cmd.number);
      end
    end
    errors        <= mismatch_count;
    outstanding   <= expected_cells.size();
    cells_checked <= checked_count;
  end

endmodule

// ===== bench/text_console_cell_writer_test.sv =====
// top of the text console cell writer testbench: clock, reset, stimulus and verdict
// depends on tccw_pkg, tccw_if.sv, the block and text_console_cell_writer_checker
module text_console_cell_writer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tccw_pkg::*;

  localparam int COLUMNS       = 80;
  localparam int ROWS          = 25;
  localparam int CLK_PERIOD    = 4;
  localparam int RESET_CYCLES  = 12;
  localparam int MAX_WAIT      = 6;
  // longest busy stretch of an item with no cell write, plus margin
  localparam int SETTLE_CYCLES = 64;
  // cycles with no transaction on any channel before giving up
  localparam int STALL_LIMIT   = 1000;
  localparam int PHASES        = 4;
  localparam int PHASE_ITEMS   = 27;
  localparam int RUSH_PHASE    = 2;
  localparam int DRAIN_PHASE   = 1;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // when set neither side inserts gaps
  bit rush = 1'b0;

  int errors;
  int outstanding;
  int cells_checked;
  int idle_cycles = 0;
  int sent_char = 0;
  int sent_newline = 0;
  int sent_dec = 0;
  int sent_hex = 0;
  int sent_unused = 0;
  int color_writes = 0;

  tccw_cmd_if  cmd_ch();
  tccw_cell_if cell_ch();
  tccw_cfg_if  cfg_ch();

  text_console_cell_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd_ch),
    .cells(cell_ch),
    .cfg  (cfg_ch)
  );

  text_console_cell_writer_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) cell_check (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd_ch),
    .cells        (cell_ch),
    .cfg          (cfg_ch),
    .errors       (errors),
    .outstanding  (outstanding),
    .cells_checked(cells_checked)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // watchdog: any transaction on any channel restarts the count
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (cell_ch.valid && cell_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // cell write sink: random stall before each transaction, ready held high
  // across back-to-back transactions when the stall is zero
  initial begin
    int stall;
    cell_ch.ready = 1'b0;
    forever begin
      stall = rush ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall != 0) begin
        cell_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      cell_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(cell_ch.valid && cell_ch.ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  // numbers of every length: tiny ones, full-width ones and shifted-down ones
  function automatic logic [NUM_W-1:0] random_number();
    case ($urandom_range(0, 3))
      0:       return NUM_W'($urandom_range(0, 15));
      1:       return NUM_W'($urandom);
      default: return NUM_W'($urandom) >> $urandom_range(0, NUM_W - 1);
    endcase
  endfunction

  // one command transaction; valid stays high on return so the next command can
  // follow back to back, callers that stop sending lower it through wait_for_drain
  task automatic send_command(input logic [MODE_W-1:0] mode, input logic [CHAR_W-1:0] ch,
                              input logic [NUM_W-1:0] num);
    int gap;
    gap = rush ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.mode      <= mode;
    cmd_ch.char_code <= ch;
    cmd_ch.number    <= num;
    @(posedge clk);
    while (!(cmd_ch.valid && cmd_ch.ready)) @(posedge clk);
    @(negedge clk);
    case (mode)
      MODE_CHAR: begin
        if (ch == NEWLINE) begin
          sent_newline++;
        end else begin
          sent_char++;
        end
      end
      MODE_DEC: sent_dec++;
      MODE_HEX: sent_hex++;
      default:  sent_unused++;
    endcase
  endtask

  // stop sending, wait for every expected cell write, then let the block settle
  task automatic wait_for_drain(input int settle);
    cmd_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // color register write, only once the block has gone quiet
  task automatic write_color(input logic [COLOR_W-1:0] c);
    wait_for_drain(SETTLE_CYCLES);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.text_color <= c;
    @(posedge clk);
    while (!(cfg_ch.valid && cfg_ch.ready)) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    color_writes++;
  endtask

  // random command; the unused mode does not count as real work
  task automatic send_random_command(input int newline_pct, output bit counted);
    int                pick;
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] ch;
    logic [NUM_W-1:0]  num;
    ch  = CHAR_W'($urandom);
    num = random_number();
    if ($urandom_range(0, 99) < newline_pct) begin
      mode = MODE_CHAR;
      ch   = NEWLINE;
    end else begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        mode = MODE_UNUSED;
      end else if (pick < 7) begin
        mode = MODE_CHAR;
      end else if (pick < 14) begin
        mode = MODE_DEC;
      end else begin
        mode = MODE_HEX;
      end
    end
    send_command(mode, ch, num);
    counted = (mode != MODE_UNUSED);
  endtask

  initial begin
    bit                 counted;
    int                 useful;
    int                 newline_pct [PHASES];
    logic [COLOR_W-1:0] phase_color [PHASES];

    cmd_ch.valid      = 1'b0;
    cmd_ch.mode       = MODE_CHAR;
    cmd_ch.char_code  = '0;
    cmd_ch.number     = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.text_color = RESET_COLOR;

    // phase 0 has no newlines so long numbers wrap lines; phase 1 is newline
    // heavy so the rows wrap past the bottom of the screen
    newline_pct[0] = 0;
    newline_pct[1] = 50;
    newline_pct[2] = 10;
    newline_pct[3] = 30;
    phase_color[0] = 8'h00;
    phase_color[1] = 8'hFF;
    phase_color[2] = COLOR_W'($urandom);
    phase_color[3] = 8'hA5;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // directed part, under the reset color
    // plain characters, lowest and highest code, number field ignored
    send_command(MODE_CHAR, "H", '1);
    send_command(MODE_CHAR, 8'h00, '0);
    send_command(MODE_CHAR, 8'hFF, NUM_W'($urandom));
    // newline mid-row gives no write
    send_command(MODE_CHAR, NEWLINE, '1);
    // unused mode is ignored whatever its fields hold
    send_command(MODE_UNUSED, "X", '1);
    send_command(MODE_UNUSED, NEWLINE, '0);
    // zero prints a single digit, char field ignored in number modes
    send_command(MODE_DEC, NEWLINE, '0);
    send_command(MODE_DEC, 8'hFF, '1);
    send_command(MODE_DEC, "7", 32'd1000000000);
    send_command(MODE_DEC, 8'h00, 32'd9);
    send_command(MODE_HEX, NEWLINE, '0);
    send_command(MODE_HEX, 8'hFF, '1);
    send_command(MODE_HEX, 8'h00, 32'h8000_0000);
    send_command(MODE_HEX, 8'h00, 32'h0000_000A);
    send_command(MODE_HEX, "Q", 32'h1234_5678);
    send_command(MODE_DEC, 8'h00, 32'd10);
    // ten-digit numbers run past the end of the line
    repeat (4) send_command(MODE_DEC, 8'h00, '1);
    send_command(MODE_CHAR, NEWLINE, '0);

    // random phases, each under its own color
    for (int phase = 0; phase < PHASES; phase++) begin
      write_color(phase_color[phase]);
      rush   = (phase == RUSH_PHASE);
      useful = 0;
      while (useful < PHASE_ITEMS) begin
        // sender holds off once until the block has emptied
        if (phase == DRAIN_PHASE && useful == PHASE_ITEMS / 2) begin
          wait_for_drain(0);
        end
        send_random_command(newline_pct[phase], counted);
        if (counted) begin
          useful++;
        end
      end
    end
    rush = 1'b0;

    wait_for_drain(SETTLE_CYCLES);
    $display("sent %0d characters, %0d newlines, %0d decimal, %0d hex, %0d unused-mode commands",
             sent_char, sent_newline, sent_dec, sent_hex, sent_unused);
    $display("checked %0d cell writes across %0d color settings",
             cells_checked, color_writes + 1);
    if (errors == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
